>>> sv/mlbp_pkg.sv
// ---------------------------------------------------------------------------
// mlbp_pkg
// Shared widths, constants and the queued item type of the bit packer.
// ---------------------------------------------------------------------------
package mlbp_pkg;

    localparam int WORD_BITS  = 64;
    localparam int LANE_BITS  = 8;
    localparam int COUNT_BITS = 7;
    localparam int FILL_BITS  = 6;
    localparam int Q_DEPTH    = 2;
    localparam int QP_BITS    = 1;
    localparam int QC_BITS    = 2;

    localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(WORD_BITS);

    // classified item, as handed from the front to the back
    typedef struct packed {
        logic [LANE_BITS-1:0]  lane;
        logic                  in_range;
        logic [COUNT_BITS-1:0] bit_count;  // saturated, 0 .. 64
        logic [WORD_BITS-1:0]  bits;       // value with bits at and above bit_count cleared
        logic [WORD_BITS-1:0]  remaining;  // value >> bit_count
    } t_item;

endpackage

>>> sv/mlbp_front.sv
// ---------------------------------------------------------------------------
// mlbp_front
// Classifies an incoming item: count saturation, lane range, masking, shift.
// ---------------------------------------------------------------------------
module mlbp_front #(
    parameter int LANES = 256
) (
    input  logic [mlbp_pkg::LANE_BITS-1:0]  i_lane,
    input  logic [mlbp_pkg::WORD_BITS-1:0]  i_value,
    input  logic [mlbp_pkg::COUNT_BITS-1:0] i_bit_count,
    output mlbp_pkg::t_item                 o_item
);
    import mlbp_pkg::*;

    logic [COUNT_BITS-1:0] n_sat;

    always_comb begin
        n_sat = (i_bit_count > MAX_COUNT) ? MAX_COUNT : i_bit_count;
        o_item.lane      = i_lane;
        o_item.in_range  = ({1'b0, i_lane} < (LANE_BITS+1)'(LANES));
        o_item.bit_count = n_sat;
        // shifts of 64 give zero, which is what the count of 64 needs
        o_item.bits      = i_value & ~({WORD_BITS{1'b1}} << n_sat);
        o_item.remaining = i_value >> n_sat;
    end

endmodule

>>> sv/mlbp_queue.sv
// ---------------------------------------------------------------------------
// mlbp_queue
// Short FIFO of classified items between the front and the back.
// ---------------------------------------------------------------------------
module mlbp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mlbp_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mlbp_pkg::t_item o_item
);
    import mlbp_pkg::*;

    t_item              r_slot [Q_DEPTH];
    logic [QP_BITS-1:0] r_wp, r_rp;
    logic [QC_BITS-1:0] r_cnt;

    assign o_full  = (r_cnt == QC_BITS'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_item;
    end

endmodule

>>> sv/mlbp_back.sv
// ---------------------------------------------------------------------------
// mlbp_back
// Lane state memory, read-modify-write packing stage and output register.
// ---------------------------------------------------------------------------
module mlbp_back #(
    parameter int LANES      = 256,
    parameter int INDEX_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  mlbp_pkg::t_item                i_q_item,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mlbp_pkg::WORD_BITS-1:0] o_remaining_value,
    output logic                           o_word_valid,
    output logic [mlbp_pkg::WORD_BITS-1:0] o_word,
    output logic [INDEX_BITS-1:0]          o_word_index
);
    import mlbp_pkg::*;

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    // lane state memory
    logic [FILL_BITS-1:0]  mem_fill [LANES];
    logic [WORD_BITS-1:0]  mem_part [LANES];
    logic [INDEX_BITS-1:0] mem_next [LANES];
    logic                  r_lane_vld [LANES];

    // packing stage
    logic                  r_p1_vld;
    t_item                 r_p1;
    logic                  r_rd_ok;
    logic [FILL_BITS-1:0]  r_rd_fill;
    logic [WORD_BITS-1:0]  r_rd_part;
    logic [INDEX_BITS-1:0] r_rd_next;
    logic                  r_fwd;
    logic [FILL_BITS-1:0]  r_fwd_fill;
    logic [WORD_BITS-1:0]  r_fwd_part;
    logic [INDEX_BITS-1:0] r_fwd_next;

    // output register
    logic                  r_o_vld;
    logic [WORD_BITS-1:0]  r_o_rem;
    logic                  r_o_wv;
    logic [WORD_BITS-1:0]  r_o_word;
    logic [INDEX_BITS-1:0] r_o_idx;

    logic                    fire, wr, full_word;
    logic [LW-1:0]           q_idx, p1_idx;
    logic [FILL_BITS-1:0]    cur_fill, n_fill;
    logic [WORD_BITS-1:0]    cur_part, n_part;
    logic [INDEX_BITS-1:0]   cur_next, n_next;
    logic [COUNT_BITS-1:0]   total;
    logic [2*WORD_BITS-1:0]  merged;

    assign fire   = r_p1_vld && (!r_o_vld || i_out_ready);
    assign o_pop  = i_q_valid && (!r_p1_vld || fire);
    assign wr     = fire && r_p1.in_range;
    assign q_idx  = i_q_item.lane[LW-1:0];
    assign p1_idx = r_p1.lane[LW-1:0];

    always_comb begin
        if (r_fwd) begin
            cur_fill = r_fwd_fill;
            cur_part = r_fwd_part;
            cur_next = r_fwd_next;
        end else if (r_rd_ok) begin
            cur_fill = r_rd_fill;
            cur_part = r_rd_part;
            cur_next = r_rd_next;
        end else begin
            cur_fill = '0;
            cur_part = '0;
            cur_next = '0;
        end
        total     = COUNT_BITS'(cur_fill) + r_p1.bit_count;
        full_word = total[FILL_BITS];
        // low half: bits of the current word, high half: overflow
        merged    = {{WORD_BITS{1'b0}}, cur_part}
                  | ({{WORD_BITS{1'b0}}, r_p1.bits} << cur_fill);
        n_fill    = total[FILL_BITS-1:0];
        n_part    = full_word ? merged[2*WORD_BITS-1:WORD_BITS] : merged[WORD_BITS-1:0];
        n_next    = full_word ? cur_next + 1'b1 : cur_next;
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem_fill[p1_idx] <= n_fill;
            mem_part[p1_idx] <= n_part;
            mem_next[p1_idx] <= n_next;
        end
        if (o_pop) begin
            r_rd_fill <= mem_fill[q_idx];
            r_rd_part <= mem_part[q_idx];
            r_rd_next <= mem_next[q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) r_lane_vld[i] <= 1'b0;
        end else if (wr) begin
            r_lane_vld[p1_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_fwd    <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else if (o_pop) begin
            r_p1_vld <= 1'b1;
            r_rd_ok  <= r_lane_vld[q_idx];
            // same lane written this cycle: memory read is stale
            r_fwd    <= wr && (r_p1.lane == i_q_item.lane);
        end else if (fire) begin
            r_p1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p1       <= i_q_item;
            r_fwd_fill <= n_fill;
            r_fwd_part <= n_part;
            r_fwd_next <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (fire) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_rem  <= r_p1.remaining;
            r_o_wv   <= wr && full_word;
            r_o_word <= (r_p1.in_range && full_word) ? merged[WORD_BITS-1:0] : '0;
            r_o_idx  <= (r_p1.in_range && full_word) ? cur_next : '0;
        end
    end

    assign o_out_valid       = r_o_vld;
    assign o_remaining_value = r_o_rem;
    assign o_word_valid      = r_o_wv;
    assign o_word            = r_o_word;
    assign o_word_index      = r_o_idx;

endmodule

>>> sv/multi_lane_bit_packer.sv
// ---------------------------------------------------------------------------
// multi_lane_bit_packer
// LSB-first variable length bit packer with per-lane 64-bit stream words.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): lane, 64-bit value and a count of
// 0..64 (larger counts act as 64). The low count bits are appended to the
// lane's partial word; a lane at or above LANES leaves all state unchanged.
// Output channel (o_out_valid / i_out_ready): exactly one item per input
// item, in order: value >> count, and when the lane's word filled up, the
// completed word with its wrapping per-lane index (word and index are zero
// otherwise).
// Throughput: one item per cycle while i_out_ready stays high, sustained even
// when consecutive items hit the same lane (the just-written lane state is
// forwarded past the memory). An accepted item passes the queue, the memory
// read and the packing into the output register, where it is offered.
// Reset clears the queue, the pipeline and the per-lane valid flags, so every
// lane restarts empty at word index zero at once; no clearing pass.
// When the receiver stalls the output register holds, the packing stage and
// the two-entry queue fill, and o_in_ready drops once the queue is full.
// ---------------------------------------------------------------------------
module multi_lane_bit_packer #(
    parameter int LANES      = 256,
    parameter int INDEX_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mlbp_pkg::LANE_BITS-1:0]  i_lane,
    input  logic [mlbp_pkg::WORD_BITS-1:0]  i_value,
    input  logic [mlbp_pkg::COUNT_BITS-1:0] i_bit_count,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mlbp_pkg::WORD_BITS-1:0]  o_remaining_value,
    output logic                            o_word_valid,
    output logic [mlbp_pkg::WORD_BITS-1:0]  o_word,
    output logic [INDEX_BITS-1:0]           o_word_index
);
    import mlbp_pkg::*;

    t_item front_item;   // classified input item
    t_item q_item;       // head of queue
    logic  q_full, q_valid, q_pop, push;

    // front: saturate count, range check, mask and remaining shift
    mlbp_front #(
        .LANES (LANES)
    ) u_front (
        .i_lane      (i_lane),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .o_item      (front_item)
    );

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    mlbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back: lane memory read, pack, write back, output register
    mlbp_back #(
        .LANES      (LANES),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_pop             (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_remaining_value (o_remaining_value),
        .o_word_valid      (o_word_valid),
        .o_word            (o_word),
        .o_word_index      (o_word_index)
    );

endmodule
